>>> rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
package rbsi_pkg;

    localparam int NUM_AXES   = 3;
    localparam int DIV_STAGES = 32;
    // divider: load, one stage per quotient bit, saturate
    localparam int DIV_LAT    = DIV_STAGES + 2;
    // lanes plus two merge stages
    localparam int CORE_LAT   = DIV_LAT + 2;
    localparam int THR_W      = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd1;

    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] ray_origin_x;
        logic signed [31:0] ray_origin_y;
        logic signed [31:0] ray_origin_z;
        logic signed [31:0] ray_dir_x;
        logic signed [31:0] ray_dir_y;
        logic signed [31:0] ray_dir_z;
        logic signed [31:0] box_low_x;
        logic signed [31:0] box_low_y;
        logic signed [31:0] box_low_z;
        logic signed [31:0] box_high_x;
        logic signed [31:0] box_high_y;
        logic signed [31:0] box_high_z;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t_near;
        logic [1:0]         entry_axis;
    } rsp_t;

    typedef struct packed {
        logic               skip;
        logic signed [31:0] t_in;
        logic signed [31:0] t_out;
    } lane_res_t;

endpackage

>>> rtl/rbsi_div.sv
`timescale 1ns / 1ps
module rbsi_div (
    input  logic        clk,
    input  logic        en,
    input  logic [32:0] num_mag,
    input  logic [31:0] den_mag,
    input  logic        neg,
    input  logic        ovf,
    output logic signed [31:0] quo
);
    import rbsi_pkg::*;

    logic [63:0] rem_reg [0:DIV_STAGES];
    logic [31:0] den_reg [0:DIV_STAGES];
    logic [31:0] q_reg   [0:DIV_STAGES];
    logic        neg_reg [0:DIV_STAGES];
    logic        ovf_reg [0:DIV_STAGES];
    logic signed [31:0] quo_reg;
    logic signed [31:0] quo_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {15'd0, num_mag, 16'd0};
            den_reg[0] <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf;
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [63:0] shd;
        logic        ge;
        always_comb
        begin
            shd = {32'd0, den_reg[s]} << (DIV_STAGES - 1 - s);
            ge  = rem_reg[s] >= shd;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? (rem_reg[s] - shd) : rem_reg[s];
                q_reg[s+1]   <= q_reg[s] | ({31'd0, ge} << (DIV_STAGES - 1 - s));
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    always_comb
    begin
        if (neg_reg[DIV_STAGES])
        begin
            if (ovf_reg[DIV_STAGES] || q_reg[DIV_STAGES] > 32'h8000_0000)
                quo_next = T_MIN;
            else
                quo_next = -$signed(q_reg[DIV_STAGES]);
        end
        else
        begin
            if (ovf_reg[DIV_STAGES] || q_reg[DIV_STAGES][31])
                quo_next = T_MAX;
            else
                quo_next = $signed(q_reg[DIV_STAGES]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

>>> rtl/rbsi_lane.sv
`timescale 1ns / 1ps
module rbsi_lane (
    input  logic        clk,
    input  logic        en,
    input  logic [rbsi_pkg::THR_W-1:0] thr,
    input  logic signed [31:0] org,
    input  logic signed [31:0] dir,
    input  logic signed [31:0] lo,
    input  logic signed [31:0] hi,
    output rbsi_pkg::lane_res_t res
);
    import rbsi_pkg::*;

    logic signed [32:0] num_a;
    logic signed [32:0] num_b;
    logic [32:0] mag_a;
    logic [32:0] mag_b;
    logic [31:0] dmag;
    logic        neg_a;
    logic        neg_b;
    logic        ovf_a;
    logic        ovf_b;
    logic        skip;
    logic signed [31:0] qa;
    logic signed [31:0] qb;
    logic        skip_reg [0:DIV_LAT-1];
    logic        dneg_reg [0:DIV_LAT-1];

    always_comb
    begin
        num_a = {lo[31], lo} - {org[31], org};
        num_b = {hi[31], hi} - {org[31], org};
        mag_a = num_a[32] ? 33'(-num_a) : 33'(num_a);
        mag_b = num_b[32] ? 33'(-num_b) : 33'(num_b);
        dmag  = dir[31] ? 32'(-dir) : 32'(dir);
        neg_a = (num_a != 33'sd0) && (num_a[32] ^ dir[31]);
        neg_b = (num_b != 33'sd0) && (num_b[32] ^ dir[31]);
        // quotient of at least 2^32 always saturates
        ovf_a = {15'd0, mag_a[32:16]} >= dmag;
        ovf_b = {15'd0, mag_b[32:16]} >= dmag;
        skip  = (dir == 32'sd0) || (dmag < {15'd0, thr});
    end

    rbsi_div u_div_a (
        .clk     (clk),
        .en      (en),
        .num_mag (mag_a),
        .den_mag (dmag),
        .neg     (neg_a),
        .ovf     (ovf_a),
        .quo     (qa)
    );

    rbsi_div u_div_b (
        .clk     (clk),
        .en      (en),
        .num_mag (mag_b),
        .den_mag (dmag),
        .neg     (neg_b),
        .ovf     (ovf_b),
        .quo     (qb)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            skip_reg[0] <= skip;
            dneg_reg[0] <= dir[31];
            for (int i = 1; i < DIV_LAT; i++)
            begin
                skip_reg[i] <= skip_reg[i-1];
                dneg_reg[i] <= dneg_reg[i-1];
            end
        end
    end

    always_comb
    begin
        res.skip  = skip_reg[DIV_LAT-1];
        res.t_in  = dneg_reg[DIV_LAT-1] ? qb : qa;
        res.t_out = dneg_reg[DIV_LAT-1] ? qa : qb;
    end

endmodule

>>> rtl/rbsi_merge.sv
`timescale 1ns / 1ps
module rbsi_merge (
    input  logic clk,
    input  logic en,
    input  rbsi_pkg::lane_res_t lane [rbsi_pkg::NUM_AXES],
    output rbsi_pkg::rsp_t rsp
);
    import rbsi_pkg::*;

    logic signed [31:0] tmin_next;
    logic signed [31:0] tmax_next;
    logic [1:0]         axis_next;
    logic signed [31:0] tmin_reg;
    logic signed [31:0] tmax_reg;
    logic [1:0]         axis_reg;
    logic               hit;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    // strict compare keeps the earlier axis on ties
    always_comb
    begin
        tmin_next = T_MIN;
        tmax_next = T_MAX;
        axis_next = 2'd0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (!lane[i].skip)
            begin
                if (lane[i].t_in > tmin_next)
                begin
                    tmin_next = lane[i].t_in;
                    axis_next = 2'(i);
                end
                if (lane[i].t_out < tmax_next)
                    tmax_next = lane[i].t_out;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
            axis_reg <= axis_next;
        end
    end

    always_comb
    begin
        hit = !(tmax_reg < tmin_reg) && !(tmax_reg[31] && tmin_reg[31]);
        rsp_next.hit        = hit;
        rsp_next.t_near     = hit ? tmin_reg : 32'sd0;
        rsp_next.entry_axis = hit ? axis_reg : 2'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

>>> rtl/ray_box_slab_intersect_core.sv
`timescale 1ns / 1ps
// a request passes through the per-axis lane dividers and the merge registers to the result
// throughput: one request per cycle unless stalled, set by the 32-stage pipelined dividers
// (two per axis lane, one quotient bit per stage)
// the whole pipeline holds while a result waits on out_ready
// reset clears the valid pipeline and sets parallel_threshold to 1
module ray_box_slab_intersect_core (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [rbsi_pkg::THR_W-1:0] cfg_wdata,
    input  logic in_valid,
    output logic in_ready,
    input  rbsi_pkg::req_t in_req,
    output logic out_valid,
    input  logic out_ready,
    output rbsi_pkg::rsp_t out_rsp
);
    import rbsi_pkg::*;

    localparam int LAT = CORE_LAT;

    logic [THR_W-1:0] thr_reg;
    logic [LAT-1:0]   vld_reg;
    logic [LAT-1:0]   vld_next;
    logic             en;
    lane_res_t        lane_res [NUM_AXES];
    logic signed [31:0] org [NUM_AXES];
    logic signed [31:0] dir [NUM_AXES];
    logic signed [31:0] lo  [NUM_AXES];
    logic signed [31:0] hi  [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_comb
    begin
        org[0] = in_req.ray_origin_x;
        org[1] = in_req.ray_origin_y;
        org[2] = in_req.ray_origin_z;
        dir[0] = in_req.ray_dir_x;
        dir[1] = in_req.ray_dir_y;
        dir[2] = in_req.ray_dir_z;
        lo[0]  = in_req.box_low_x;
        lo[1]  = in_req.box_low_y;
        lo[2]  = in_req.box_low_z;
        hi[0]  = in_req.box_high_x;
        hi[1]  = in_req.box_high_y;
        hi[2]  = in_req.box_high_z;
    end

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        rbsi_lane u_lane (
            .clk   (clk),
            .en    (en),
            .thr   (thr_reg),
            .org   (org[a]),
            .dir   (dir[a]),
            .lo    (lo[a]),
            .hi    (hi[a]),
            .res   (lane_res[a])
        );
    end

    rbsi_merge u_merge (
        .clk   (clk),
        .en    (en),
        .lane  (lane_res),
        .rsp   (out_rsp)
    );

    assign out_valid = vld_reg[LAT-1];

endmodule
